/* src/psle_pkg.sv */
// ============================================================================
// psle_pkg
// Shared types and constants for the positional sorted list engine.
// ============================================================================
`default_nettype none

package psle_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int NUMBER_W = 4;
    localparam int SUIT_W   = 3;
    localparam int COUNT_W  = 7;
    localparam int CARD_W   = 6;

    localparam logic [KIND_W-1:0] REQ_APPEND     = 3'd0;
    localparam logic [KIND_W-1:0] REQ_INSERT_AT  = 3'd1;
    localparam logic [KIND_W-1:0] REQ_SORTED_INS = 3'd2;
    localparam logic [KIND_W-1:0] REQ_REMOVE_END = 3'd3;
    localparam logic [KIND_W-1:0] REQ_REMOVE_AT  = 3'd4;
    localparam logic [KIND_W-1:0] REQ_FIND       = 3'd5;
    localparam logic [KIND_W-1:0] REQ_READ_AT    = 3'd6;
    localparam logic [KIND_W-1:0] REQ_CLEAR      = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [POS_W-1:0]    position;
        logic [NUMBER_W-1:0] number;
        logic [SUIT_W-1:0]   suit;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [POS_W-1:0]    position;
        logic [NUMBER_W-1:0] number;
        logic [SUIT_W-1:0]   suit;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

`default_nettype wire

/* src/positional_sorted_list_engine_core.sv */
// ============================================================================
// positional_sorted_list_engine_core
// Ordered card list with positional and sorted insert, remove, find, read.
// ============================================================================
// One request word in gives one result word out. The list lives in a
// single-port-read memory and every scan or shift step is a read followed
// by a write or a compare. Append, read at, clear and any rejected request
// need no scan or shift; insert at and remove at or remove last shift the
// entries behind the position, find scans from the front until a hit or the
// end, and sorted insert scans for the first entry whose number is not below
// its own and then shifts up (no shift when the card lands at the end). The
// block accepts one request at a time; a finished result waits in the output
// register while the next request is taken, and the sequencer only stalls
// when that register is still held, waiting for m_tready.
`default_nettype none

module positional_sorted_list_engine_core #(
    parameter int DEPTH = psle_pkg::DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // position[6:0], card_number[10:7],
                                        // card_suit[13:11], zero[15:14]
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // ok[0], found_position[7:1],
                                        // out_number[11:8], out_suit[14:12],
                                        // entry_count[21:15], zero[23:22]
);
    import psle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    req_t              req;
    res_t              res;
    logic              res_valid;
    logic              out_free;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CARD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CARD_W-1:0] mem_rdata;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;

    assign req.kind     = s_tuser;
    assign req.position = s_tdata[6:0];
    assign req.number   = s_tdata[10:7];
    assign req.suit     = s_tdata[13:11];

    assign out_free = !m_tvalid_reg || m_tready;

    psle_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    psle_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && out_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, res.count, res.suit, res.number,
                             res.position, res.ok};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* src/psle_mem.sv */
// ============================================================================
// psle_mem
// Entry store: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module psle_mem #(
    parameter int DEPTH = psle_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [psle_pkg::CARD_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [psle_pkg::CARD_W-1:0] rdata
);
    import psle_pkg::*;

    logic [CARD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/psle_ctrl.sv */
// ============================================================================
// psle_ctrl
// Request sequencer: scans and shifts the entry store one entry per step.
// ============================================================================
`default_nettype none

module psle_ctrl #(
    parameter int DEPTH = psle_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire psle_pkg::req_t              req,
    output logic                             res_valid,
    input  wire logic                        out_free,
    output psle_pkg::res_t                   res,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [psle_pkg::CARD_W-1:0]      mem_wdata,
    output logic [AW-1:0]                    mem_raddr,
    input  wire logic [psle_pkg::CARD_W-1:0] mem_rdata
);
    import psle_pkg::*;

    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_SCAN_RD  = 11'b00000000010,
        ST_SCAN_CHK = 11'b00000000100,
        ST_SHUP_RD  = 11'b00000001000,
        ST_SHUP_WR  = 11'b00000010000,
        ST_PUT      = 11'b00000100000,
        ST_GET_RD   = 11'b00001000000,
        ST_GET_WAIT = 11'b00010000000,
        ST_SHDN_RD  = 11'b00100000000,
        ST_SHDN_WR  = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [NUMBER_W-1:0] num_reg, num_next;
    logic [CARD_W-1:0]   card_reg, card_next;
    res_t                res_reg, res_next;

    logic                accept;
    logic                full;
    logic [PW-1:0]       pos_w;
    logic [PW-1:0]       len_w;
    logic [PW-1:0]       pos_m1_w;
    logic [PW-1:0]       idx_p1_w;
    logic [PW-1:0]       ptr_p1_w;
    logic                pos_ok_rd;
    logic                pos_ok_ins;
    logic [CW-1:0]       ptr_inc;
    logic [CW-1:0]       ptr_dec;
    logic [NUMBER_W-1:0] rd_number;
    logic [SUIT_W-1:0]   rd_suit;
    res_t                res_fail;

    assign accept     = req_valid && (state_reg == ST_IDLE);
    assign full       = (len_reg == CW'(DEPTH));
    assign pos_w      = PW'(req.position);
    assign len_w      = PW'(len_reg);
    assign pos_m1_w   = pos_w - PW'(1);
    assign idx_p1_w   = PW'(idx_reg) + PW'(1);
    assign ptr_p1_w   = PW'(ptr_reg) + PW'(1);
    assign pos_ok_rd  = (pos_w != '0) && (pos_w <= len_w);
    assign pos_ok_ins = (pos_w != '0) && (pos_w <= len_w + PW'(1));
    assign ptr_inc    = ptr_reg + CW'(1);
    assign ptr_dec    = ptr_reg - CW'(1);
    assign rd_number  = mem_rdata[NUMBER_W-1:0];
    assign rd_suit    = {1'b0, mem_rdata[CARD_W-1:NUMBER_W]} + SUIT_W'(1);
    assign res_fail   = '0;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        num_next   = num_reg;
        card_next  = card_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg[AW-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req.kind;
                    num_next   = req.number;
                    card_next  = {req.suit[1:0] + 2'd3, req.number};
                    res_next   = res_fail;
                    state_next = ST_DONE;
                    unique case (req.kind)
                        REQ_APPEND:
                        begin
                            if (!full)
                            begin
                                idx_next   = len_reg;
                                state_next = ST_PUT;
                            end
                        end
                        REQ_INSERT_AT:
                        begin
                            if (!full && pos_ok_ins)
                            begin
                                idx_next   = CW'(pos_m1_w);
                                ptr_next   = len_reg;
                                state_next = ST_SHUP_RD;
                            end
                        end
                        REQ_SORTED_INS:
                        begin
                            if (!full)
                            begin
                                ptr_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        REQ_REMOVE_END:
                        begin
                            if (len_reg != '0)
                            begin
                                idx_next   = len_reg - CW'(1);
                                state_next = ST_GET_RD;
                            end
                        end
                        REQ_REMOVE_AT, REQ_READ_AT:
                        begin
                            if (pos_ok_rd)
                            begin
                                idx_next   = CW'(pos_m1_w);
                                state_next = ST_GET_RD;
                            end
                        end
                        REQ_FIND:
                        begin
                            ptr_next   = '0;
                            state_next = ST_SCAN_RD;
                        end
                        REQ_CLEAR:
                        begin
                            len_next    = '0;
                            res_next.ok = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                if (ptr_reg == len_reg)
                begin
                    if (kind_reg == REQ_SORTED_INS)
                    begin
                        idx_next   = len_reg;
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (kind_reg == REQ_SORTED_INS)
                begin
                    if (num_reg <= rd_number)
                    begin
                        idx_next   = ptr_reg;
                        ptr_next   = len_reg;
                        state_next = ST_SHUP_RD;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = ST_SCAN_RD;
                    end
                end
                else if (num_reg == rd_number)
                begin
                    res_next.ok       = 1'b1;
                    res_next.position = ptr_p1_w[POS_W-1:0];
                    res_next.number   = rd_number;
                    res_next.suit     = rd_suit;
                    state_next        = ST_DONE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHUP_RD:
            begin
                mem_raddr = ptr_dec[AW-1:0];
                if (ptr_reg == idx_reg)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_SHUP_WR;
                end
            end
            ST_SHUP_WR:
            begin
                mem_we     = 1'b1;
                ptr_next   = ptr_dec;
                state_next = ST_SHUP_RD;
            end
            ST_PUT:
            begin
                mem_we            = 1'b1;
                mem_waddr         = idx_reg[AW-1:0];
                mem_wdata         = card_reg;
                len_next          = len_reg + CW'(1);
                res_next.ok       = 1'b1;
                res_next.position = idx_p1_w[POS_W-1:0];
                state_next        = ST_DONE;
            end
            ST_GET_RD:
            begin
                mem_raddr  = idx_reg[AW-1:0];
                state_next = ST_GET_WAIT;
            end
            ST_GET_WAIT:
            begin
                res_next.ok       = 1'b1;
                res_next.position = idx_p1_w[POS_W-1:0];
                res_next.number   = rd_number;
                res_next.suit     = rd_suit;
                ptr_next          = idx_reg;
                if (kind_reg == REQ_READ_AT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SHDN_RD;
                end
            end
            ST_SHDN_RD:
            begin
                mem_raddr = ptr_inc[AW-1:0];
                if (ptr_inc == len_reg)
                begin
                    len_next   = len_reg - CW'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SHDN_WR;
                end
            end
            ST_SHDN_WR:
            begin
                mem_we     = 1'b1;
                ptr_next   = ptr_inc;
                state_next = ST_SHDN_RD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        num_reg  <= num_next;
        card_reg <= card_next;
        res_reg  <= res_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res       = res_reg;
        res.count = len_w[COUNT_W-1:0];
    end

    // checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CW'(DEPTH))
        else $error("list length above depth");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (len_reg == $past(len_reg)
            || len_reg == $past(len_reg) + CW'(1)
            || len_reg == $past(len_reg) - CW'(1)))
        else $error("length moved by more than one");

    a_shift_up_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHUP_WR) |-> (ptr_reg > idx_reg && ptr_reg <= len_reg))
        else $error("shift up outside list");

    a_shift_dn_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHDN_WR) |-> (ptr_inc < len_reg))
        else $error("shift down outside list");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("ready right after accept");

endmodule

`default_nettype wire
